// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by the top-level encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   `ASSERT_CHECK(label, clk, rst, !(cond))

`endif

// ===== rtl/core/u16esc_pkg.sv =====
`timescale 1ns / 1ps

package u16esc_pkg;

   // ASCII codes used by the encoder
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_HEX_ALPHA = 8'h37;

   // Default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // What the back end does with a queued word
   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_ESCAPE,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] unit;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ESC_U,
      ST_HEX3,
      ST_HEX2,
      ST_HEX1,
      ST_HEX0
   } back_state_type;

   // Upper-case ASCII hex digit of one nibble
   function automatic logic [7:0] hex_ascii(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'h0, nibble};
      if (nibble < 4'd10) begin
         hex_ascii = CHAR_ZERO + wide;
      end else begin
         hex_ascii = CHAR_HEX_ALPHA + wide;
      end
   endfunction

endpackage

// ===== rtl/core/u16esc_front.sv =====
`timescale 1ns / 1ps

module u16esc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [15:0]             req_code_unit,
   input  logic                    req_last_unit,
   input  u16esc_pkg::q_status_type q_status,
   output logic                    push,
   output u16esc_pkg::entry_type   push_entry
);
   import u16esc_pkg::*;

   logic stopped_ff;
   logic stopped_in;
   logic accept;
   logic is_zero;
   logic is_plain;

   // Hold the input while the queue is full
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   // Classify the unit
   assign is_zero  = (req_code_unit == 16'h0000);
   assign is_plain = (req_code_unit[15:8] == 8'h00)
                     && (req_code_unit[7:0] >= CHAR_SPACE)
                     && (req_code_unit[7:0] <= CHAR_TILDE)
                     && (req_code_unit[7:0] != CHAR_QUOTE)
                     && (req_code_unit[7:0] != CHAR_BACKSLASH);

   always_comb begin
      push_entry.unit = req_code_unit;
      if (is_zero) begin
         push_entry.kind = KIND_END;
      end else if (is_plain) begin
         push_entry.kind = KIND_PASS;
      end else begin
         push_entry.kind = KIND_ESCAPE;
      end
   end

   // Drop words while the string is stopped
   assign push = accept && !stopped_ff;

   // Stop after a zero unit; the last unit of a buffer restarts
   always_comb begin
      stopped_in = stopped_ff;
      if (accept && (stopped_ff || is_zero)) begin
         stopped_in = !req_last_unit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== rtl/core/u16esc_queue.sv =====
`timescale 1ns / 1ps

module u16esc_queue #(
   parameter int unsigned DEPTH = u16esc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  u16esc_pkg::entry_type    push_entry,
   input  logic                     pop,
   output u16esc_pkg::entry_type    pop_entry,
   output u16esc_pkg::q_status_type q_status
);
   import u16esc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign pop_entry          = entries_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (count_ff != '0);

   // Advance pointers with wrap
   assign wr_ptr_in = !push ? wr_ptr_ff : ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1);
   assign rd_ptr_in = !pop  ? rd_ptr_ff : ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1);

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/u16esc_back.sv =====
`timescale 1ns / 1ps

module u16esc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  u16esc_pkg::q_status_type q_status,
   input  u16esc_pkg::entry_type    pop_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_run_last,
   output logic                     rsp_string_end
);
   import u16esc_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;
   logic [15:0]    unit_ff;
   logic [15:0]    unit_in;
   logic           advance;
   logic           emit;
   logic [7:0]     emit_char;
   logic           emit_last;
   logic           emit_end;
   logic           valid_ff;
   logic           valid_in;
   logic [7:0]     char_ff;
   logic           last_ff;
   logic           end_ff;

   // Output register is free when empty or being taken
   assign advance = !valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (advance && q_status.not_empty && (pop_entry.kind == KIND_ESCAPE)) begin
               state_in = ST_ESC_U;
            end
         end
         ST_ESC_U: if (advance) state_in = ST_HEX3;
         ST_HEX3:  if (advance) state_in = ST_HEX2;
         ST_HEX2:  if (advance) state_in = ST_HEX1;
         ST_HEX1:  if (advance) state_in = ST_HEX0;
         ST_HEX0:  if (advance) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Byte selection for each state
   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_char = CHAR_NUL;
      emit_last = 1'b0;
      emit_end  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (advance && q_status.not_empty) begin
               pop  = 1'b1;
               emit = 1'b1;
               case (pop_entry.kind)
                  KIND_PASS: begin
                     emit_char = pop_entry.unit[7:0];
                     emit_last = 1'b1;
                  end
                  KIND_ESCAPE: begin
                     emit_char = CHAR_BACKSLASH;
                  end
                  KIND_END: begin
                     emit_char = CHAR_NUL;
                     emit_last = 1'b1;
                     emit_end  = 1'b1;
                  end
                  default: begin
                     emit_last = 1'b1;
                  end
               endcase
            end
         end
         ST_ESC_U: begin
            emit      = advance;
            emit_char = CHAR_LOWER_U;
         end
         ST_HEX3: begin
            emit      = advance;
            emit_char = hex_ascii(unit_ff[15:12]);
         end
         ST_HEX2: begin
            emit      = advance;
            emit_char = hex_ascii(unit_ff[11:8]);
         end
         ST_HEX1: begin
            emit      = advance;
            emit_char = hex_ascii(unit_ff[7:4]);
         end
         ST_HEX0: begin
            emit      = advance;
            emit_char = hex_ascii(unit_ff[3:0]);
            emit_last = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Latch the unit when it leaves the queue
   assign unit_in  = pop ? pop_entry.unit : unit_ff;
   assign valid_in = emit ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output word
   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      if (emit) begin
         char_ff <= emit_char;
         last_ff <= emit_last;
         end_ff  <= emit_end;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_string_end = end_ff;

endmodule

// ===== rtl/core/utf16_unicode_escape_encoder.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// UTF-16 to ASCII escape encoder. Each request word carries one code unit and
// yields one response byte when it is printable ASCII other than quote and
// backslash, six bytes (backslash, 'u', four upper-case hex digits) for any
// other nonzero unit, and a single zero byte with string_end set for a zero
// unit; after a zero unit the remaining units up to the one flagged last give
// no bytes. The front end accepts one request per cycle into a small queue
// (QUEUE_DEPTH words) and stalls only when that queue is full; the back end
// sequencer emits one byte per cycle, unless rsp_stall holds it, through a
// registered output, so a passed or end-marker unit takes one byte, an
// escaped unit six bytes, and a skipped unit none of the output bandwidth.

module utf16_unicode_escape_encoder #(
   parameter int unsigned QUEUE_DEPTH = u16esc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);
   import u16esc_pkg::*;

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    pop_entry;
   logic         push;
   logic         pop;
   logic         end_word;
   logic         end_shape;
   logic         esc_taken;
   logic         u_word;

   u16esc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   u16esc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   u16esc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // Decode response words for the checks below
   assign end_word  = rsp_valid && rsp_string_end;
   assign end_shape = (rsp_out_char == CHAR_NUL) && rsp_run_last;
   assign esc_taken = rsp_valid && !rsp_stall && !rsp_run_last
                      && (rsp_out_char == CHAR_BACKSLASH);
   assign u_word    = rsp_valid && (rsp_out_char == CHAR_LOWER_U);

   // Queue never overflows or underflows
   `ASSERT_NEVER(a_no_push_full, clock, reset, push && q_status.full)
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !q_status.not_empty)

   // End marker is a lone zero byte
   `ASSERT_CHECK(a_end_marker, clock, reset, end_word |-> end_shape)

   // A taken escape backslash is followed at once by 'u'
   `ASSERT_CHECK(a_escape_u, clock, reset, esc_taken |=> u_word)

endmodule
